// ----- rtl/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// tch_pkg
// Shared types, widths and constants of the triangle check / Heron area block.
// ----------------------------------------------------------------------------
`default_nettype none

package tch_pkg;

  // Width of one side length (unsigned Q8.8 at 16).
  localparam int SIDE_WIDTH = 16;
  localparam int AREA_WIDTH = 31;

  // Sum of three sides and the difference factors (b+c-a etc.).
  localparam int SUM_W   = SIDE_WIDTH + 2;
  localparam int DIF_W   = SIDE_WIDTH + 1;

  // f1 = (a+b+c)(b+c-a), f2 = (a+c-b)(a+b-c)
  localparam int F1_W    = SUM_W + DIF_W;
  localparam int F2_W    = 2 * DIF_W;

  // f1 * f2 is built from two partial products over the halves of f2.
  localparam int F2_LO_W = DIF_W;
  localparam int F2_HI_W = F2_W - F2_LO_W;
  localparam int PP_LO_W = F1_W + F2_LO_W;
  localparam int PP_HI_W = F1_W + F2_HI_W;
  localparam int PROD_W  = F1_W + F2_W;

  // Square root: two result bits per stage.
  localparam int SQ_STAGES = (PROD_W + 3) / 4;
  localparam int RAD_W     = 4 * SQ_STAGES;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;

  localparam logic [63:0] AREA_MAX = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic [SIDE_WIDTH-1:0] side_a;
    logic [SIDE_WIDTH-1:0] side_b;
    logic [SIDE_WIDTH-1:0] side_c;
  } tch_in_t;

  typedef struct packed {
    logic                  is_triangle;
    logic [AREA_WIDTH-1:0] area;
  } tch_out_t;

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic vld;
    logic ok;
  } tch_ctl_t;

  // Working state of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } tch_sq_t;

endpackage

`default_nettype wire

// ----- rtl/tch_factors.sv -----
// ----------------------------------------------------------------------------
// tch_factors
// Register the sides, check the triangle, form the two Heron factor products.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_factors (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire tch_pkg::tch_in_t               in_i,
  output tch_pkg::tch_ctl_t                   ctl_o,
  output logic [tch_pkg::F1_W-1:0]            f1_o,
  output logic [tch_pkg::F2_W-1:0]            f2_o
);

  localparam int SW = tch_pkg::SIDE_WIDTH;
  localparam int SU = tch_pkg::SUM_W;
  localparam int DW = tch_pkg::DIF_W;

  // Stage A: sides
  logic          vld_a_q;
  logic [SW-1:0] a_q, b_q, c_q;

  // Stage B: sum and differences
  tch_pkg::tch_ctl_t ctl_b_q, ctl_b_d;
  logic [SU-1:0]     s_q, s_d;
  logic [DW-1:0]     d1_q, d2_q, d3_q, d1_d, d2_d, d3_d;

  // Stage C: factor products
  tch_pkg::tch_ctl_t          ctl_c_q;
  logic [tch_pkg::F1_W-1:0]   f1_q;
  logic [tch_pkg::F2_W-1:0]   f2_q;

  logic [SU-1:0] ea, eb, ec, ab, bc, ac;
  logic          ok;

  always_comb begin
    ea = SU'(a_q);
    eb = SU'(b_q);
    ec = SU'(c_q);
    ab = ea + eb;
    bc = eb + ec;
    ac = ea + ec;
    ok = (|a_q) && (|b_q) && (|c_q) && (ab > ec) && (bc > ea) && (ac > eb);
    ctl_b_d.vld = vld_a_q;
    ctl_b_d.ok  = ok;
    // zero the factors of an invalid set so the root comes out zero
    s_d  = ok ? (ab + ec) : '0;
    d1_d = ok ? DW'(bc - ea) : '0;
    d2_d = ok ? DW'(ac - eb) : '0;
    d3_d = ok ? DW'(ab - ec) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      ctl_b_q <= ctl_b_d;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= in_i.side_a;
      b_q  <= in_i.side_b;
      c_q  <= in_i.side_c;
      s_q  <= s_d;
      d1_q <= d1_d;
      d2_q <= d2_d;
      d3_q <= d3_d;
      f1_q <= tch_pkg::F1_W'(s_q) * tch_pkg::F1_W'(d1_q);
      f2_q <= tch_pkg::F2_W'(d2_q) * tch_pkg::F2_W'(d3_q);
    end
  end

  assign ctl_o = ctl_c_q;
  assign f1_o  = f1_q;
  assign f2_o  = f2_q;

endmodule

`default_nettype wire

// ----- rtl/tch_mult.sv -----
// ----------------------------------------------------------------------------
// tch_mult
// Wide product f1 * f2 from two registered partial products and one add.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_mult (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire tch_pkg::tch_ctl_t        ctl_i,
  input  wire logic [tch_pkg::F1_W-1:0] f1_i,
  input  wire logic [tch_pkg::F2_W-1:0] f2_i,
  output tch_pkg::tch_ctl_t             ctl_o,
  output logic [tch_pkg::RAD_W-1:0]     rad_o
);

  localparam int LW = tch_pkg::PP_LO_W;
  localparam int HW = tch_pkg::PP_HI_W;
  localparam int RW = tch_pkg::RAD_W;

  tch_pkg::tch_ctl_t ctl_d_q, ctl_e_q;
  logic [LW-1:0]     pp_lo_q;
  logic [HW-1:0]     pp_hi_q;
  logic [RW-1:0]     prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '0;
      ctl_e_q <= '0;
    end else if (en_i) begin
      ctl_d_q <= ctl_i;
      ctl_e_q <= ctl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= LW'(f1_i) * LW'(f2_i[tch_pkg::F2_LO_W-1:0]);
      pp_hi_q <= HW'(f1_i) * HW'(f2_i[tch_pkg::F2_W-1:tch_pkg::F2_LO_W]);
      prod_q  <= RW'(pp_lo_q) + (RW'(pp_hi_q) << tch_pkg::F2_LO_W);
    end
  end

  assign ctl_o = ctl_e_q;
  assign rad_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/tch_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// tch_sqrt_stage
// One register stage of the restoring square root: two root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_sqrt_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire tch_pkg::tch_ctl_t ctl_i,
  input  wire tch_pkg::tch_sq_t  sq_i,
  output tch_pkg::tch_ctl_t      ctl_o,
  output tch_pkg::tch_sq_t       sq_o
);

  localparam int RW = tch_pkg::RAD_W;
  localparam int MW = tch_pkg::REM_W;
  localparam int TW = tch_pkg::ROOT_W;

  tch_pkg::tch_ctl_t ctl_q;
  tch_pkg::tch_sq_t  sq_q, sq_d;
  logic [RW-1:0]     rad;
  logic [MW-1:0]     rem, trial;
  logic [TW-1:0]     root;

  always_comb begin
    rad  = sq_i.rad;
    rem  = sq_i.rem;
    root = sq_i.root;
    for (int k = 0; k < 2; k++) begin
      // bring down the next two radicand bits, try root*4+1
      rem   = {rem[MW-3:0], rad[RW-1:RW-2]};
      rad   = {rad[RW-3:0], 2'b00};
      trial = {MW'(root) << 2} | MW'(1);
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[TW-2:0], 1'b1};
      end else begin
        root = {root[TW-2:0], 1'b0};
      end
    end
    sq_d.rad  = rad;
    sq_d.rem  = rem;
    sq_d.root = root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign ctl_o = ctl_q;
  assign sq_o  = sq_q;

endmodule

`default_nettype wire

// ----- rtl/triangle_check_heron_area.sv -----
// ----------------------------------------------------------------------------
// triangle_check_heron_area
// Triangle validity check and Heron area of three Q8.8 sides, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one item of three unsigned Q8.8 sides per cycle and returns, in order,
// one result per item: is_triangle (all sides nonzero and all three strict
// triangle inequalities hold) and the area in unsigned Q15.16, rounded down,
// computed exactly as floor(isqrt((a+b+c)(b+c-a)(a+c-b)(a+b-c)) / 4); an
// invalid set gives area 0. Throughput is one item per cycle with no gaps while
// stall_o is low; most of the pipeline depth is the square-root pipeline
// (two root bits per stage over a 72-bit radicand). The stages are three for
// the sides, sums and factor products, two for the wide product, SQ_STAGES for
// the root and one output register. The whole pipeline advances together:
// stall_o rises only while a result sits in the output register and the
// downstream side holds stall_i high, so a bubble in the output register never
// holds the pipeline, and nothing is lost or repeated on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_check_heron_area (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire tch_pkg::tch_in_t  in_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output tch_pkg::tch_out_t      out_o
);

  localparam int NS = tch_pkg::SQ_STAGES;
  localparam int TW = tch_pkg::ROOT_W;

  // Advance every stage unless the finished result is held downstream.
  logic en;

  tch_pkg::tch_ctl_t          ctl_fac, ctl_mul;
  logic [tch_pkg::F1_W-1:0]   f1;
  logic [tch_pkg::F2_W-1:0]   f2;
  logic [tch_pkg::RAD_W-1:0]  rad;

  tch_pkg::tch_ctl_t ctl_w [NS+1];
  tch_pkg::tch_sq_t  sq_w  [NS+1];

  logic              out_vld_q;
  tch_pkg::tch_out_t out_q, out_d;
  logic [TW-3:0]     quarter;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  tch_factors u_factors (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .in_i    (in_i),
    .ctl_o   (ctl_fac),
    .f1_o    (f1),
    .f2_o    (f2)
  );

  tch_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_fac),
    .f1_i   (f1),
    .f2_i   (f2),
    .ctl_o  (ctl_mul),
    .rad_o  (rad)
  );

  // Seed the root: remainder and root start at zero.
  assign ctl_w[0]     = ctl_mul;
  assign sq_w[0].rad  = rad;
  assign sq_w[0].rem  = '0;
  assign sq_w[0].root = '0;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    tch_sqrt_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_w[g]),
      .sq_i   (sq_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .sq_o   (sq_w[g+1])
    );
  end

  // Divide the root by four (drop its two low bits) and clamp to the area field.
  always_comb begin
    quarter = sq_w[NS].root[TW-1:2];
    out_d.is_triangle = ctl_w[NS].ok;
    if (!ctl_w[NS].ok) begin
      out_d.area = '0;
    end else if (64'(quarter) > tch_pkg::AREA_MAX) begin
      out_d.area = tch_pkg::AREA_WIDTH'(tch_pkg::AREA_MAX);
    end else begin
      out_d.area = tch_pkg::AREA_WIDTH'(quarter);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_w[NS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign out_o   = out_q;

  // An invalid set never reports a nonzero area.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.is_triangle) |-> (out_o.area == '0))
    else $error("invalid triangle with nonzero area");

  // Input stall only ever comes from a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a held result");

  // A stalled pipeline keeps its last root stage unchanged.
  a_hold_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl_w[NS]) && $stable(sq_w[NS]))
    else $error("root stage changed during a stall");

  // A root marked valid-triangle comes from a nonzero radicand.
  a_ok_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_w[NS].vld && ctl_w[NS].ok) |-> (sq_w[NS].root != '0))
    else $error("valid triangle with zero root");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle check / Heron area pipeline.
// ----------------------------------------------------------------------------
// Feeds items of three Q8.8 sides through the valid/stall input channel.
// Every accepted item is run through a local exact-integer predictor: side
// checks, the Heron product and a bitwise integer square root. The predicted
// result is queued. Each result taken from the output channel is compared
// field by field with the oldest queued prediction. Both channels idle or
// stall at random, with a back-to-back stretch and full drain pauses. A
// watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SW             = tch_pkg::SIDE_WIDTH;
  localparam int unsigned SIDE_MAX       = (1 << SW) - 1;
  localparam int unsigned SMALL_MAX      = 255;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned BURST_ITEMS    = 300;
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BUSY_PCT       = 21;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  tch_pkg::tch_in_t   in_i;
  logic               valid_o;
  logic               stall_i;
  tch_pkg::tch_out_t  out_o;

  // Idle and stall odds in percent; both drop to zero for the back-to-back run.
  int unsigned idle_pct;
  int unsigned stall_pct;

  tch_pkg::tch_out_t area_expected[$];
  int unsigned       mismatch_count;
  int unsigned       quiet_cycles;

  triangle_check_heron_area u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .in_i    (in_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .out_o   (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Exact triangle check and Heron area in Q15.16, rounded down.
  function automatic tch_pkg::tch_out_t heron_area_of(tch_pkg::tch_in_t s);
    bit [63:0]         a, b, c;
    bit [63:0]         f1, f2;
    bit [127:0]        radicand, square;
    bit [63:0]         root, trial, area;
    bit                ok;
    tch_pkg::tch_out_t r;
    a = 64'(s.side_a);
    b = 64'(s.side_b);
    c = 64'(s.side_c);
    ok = (a != 0) && (b != 0) && (c != 0) &&
         (a + b > c) && (b + c > a) && (a + c > b);
    area = '0;
    if (ok) begin
      f1 = (a + b + c) * (b + c - a);
      f2 = (a + c - b) * (a + b - c);
      radicand = {64'd0, f1} * {64'd0, f2};
      // Build the root one bit at a time from the top; the root fits 48 bits
      // for any side width up to 23.
      root = '0;
      for (int i = 47; i >= 0; i--) begin
        trial  = root | (64'd1 << i);
        square = {64'd0, trial} * {64'd0, trial};
        if (square <= radicand) root = trial;
      end
      area = root >> 2;
      if (area > tch_pkg::AREA_MAX) area = tch_pkg::AREA_MAX;
    end
    r.is_triangle = ok;
    r.area        = area[tch_pkg::AREA_WIDTH-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard and watchdog
  // --------------------------------------------------------------------------
  // Sample both channels at the rising edge. Queue the prediction for an
  // accepted input before checking an accepted output, so the order within
  // this process alone decides what is compared.
  always @(posedge clk_i) begin : scoreboard
    tch_pkg::tch_out_t want;
    if (rst_ni) begin
      if (valid_i && !stall_o) area_expected.push_back(heron_area_of(in_i));
      if (valid_o && !stall_i) begin
        if (area_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got is_triangle=%0b area=%h",
                   $time, out_o.is_triangle, out_o.area);
          mismatch_count++;
        end else begin
          want = area_expected.pop_front();
          if (out_o.is_triangle !== want.is_triangle) begin
            $display("%0t: is_triangle mismatch, expected %0b, got %0b",
                     $time, want.is_triangle, out_o.is_triangle);
            mismatch_count++;
          end
          if (out_o.area !== want.area) begin
            $display("%0t: area mismatch, expected %h, got %h",
                     $time, want.area, out_o.area);
            mismatch_count++;
          end
        end
      end
      // Count cycles in which neither channel moves an item.
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall at random; one assignment per falling edge.
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Present one item at a falling edge, after any random idle, and hold it until accepted.
  // While idle, scramble the payload so nothing leaks through a low valid.
  task automatic send_sides(input logic [SW-1:0] a,
                            input logic [SW-1:0] b,
                            input logic [SW-1:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      in_i    <= tch_pkg::tch_in_t'({SW'($urandom), SW'($urandom), SW'($urandom)});
      @(negedge clk_i);
    end
    valid_i     <= 1'b1;
    in_i.side_a <= a;
    in_i.side_b <= b;
    in_i.side_c <= c;
    do @(posedge clk_i); while (stall_o);
  endtask

  // Send three sides in a random order, so any position carries the
  // constrained side.
  task automatic send_shuffled(input int unsigned x, input int unsigned y,
                               input int unsigned z);
    logic [SW-1:0] p, q, r;
    p = SW'(x);
    q = SW'(y);
    r = SW'(z);
    case ($urandom_range(5))
      0: send_sides(p, q, r);
      1: send_sides(p, r, q);
      2: send_sides(q, p, r);
      3: send_sides(q, r, p);
      4: send_sides(r, p, q);
      default: send_sides(r, q, p);
    endcase
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (area_expected.size() != 0) @(posedge clk_i);
  endtask

  // One random item: mostly proper triangles, some degenerate, some with a
  // zero side, some pure noise. A third of the sizes stay small.
  task automatic send_random_item();
    int unsigned top, x, y, lo, hi, pick;
    top  = ($urandom_range(2) == 0) ? SMALL_MAX : SIDE_MAX;
    pick = $urandom_range(99);
    x = $urandom_range(1, top);
    y = $urandom_range(1, top);
    if (pick < 75) begin
      lo = ((x > y) ? x - y : y - x) + 1;
      hi = x + y - 1;
      if (hi > top) hi = top;
      send_shuffled(x, y, $urandom_range(lo, hi));
    end else if (pick < 85) begin
      // Degenerate: one side equals the sum of the other two.
      if (x + y > top) x = top - y + $urandom_range(0, 0);
      if (x == 0) x = 1;
      if (x + y <= SIDE_MAX) send_shuffled(x, y, x + y);
      else send_shuffled(x, y, $urandom_range(1, top));
    end else if (pick < 90) begin
      send_shuffled(0, x, y);
    end else begin
      send_sides(SW'($urandom_range(0, SIDE_MAX)), SW'($urandom_range(0, SIDE_MAX)),
                 SW'($urandom_range(0, SIDE_MAX)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, each failing inequality, degenerate and zero sides.
  task automatic test_directed();
    send_sides(16'h0000, 16'h0000, 16'h0000);
    send_sides(16'h0000, 16'h0005, 16'h0005);
    send_sides(16'h0005, 16'h0000, 16'h0005);
    send_sides(16'h0005, 16'h0005, 16'h0000);
    send_sides(16'h0001, 16'h0001, 16'h0001);
    send_sides(16'h000A, 16'h0001, 16'h0001);
    send_sides(16'h0001, 16'h000A, 16'h0001);
    send_sides(16'h0001, 16'h0001, 16'h000A);
    send_sides(16'h0002, 16'h0001, 16'h0001);
    send_sides(16'h0001, 16'h0002, 16'h0001);
    send_sides(16'h0001, 16'h0001, 16'h0002);
    send_sides(16'h0300, 16'h0400, 16'h0500);
    send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sides(16'hFFFF, 16'hFFFF, 16'h0001);
    send_sides(16'hFFFF, 16'h0001, 16'hFFFF);
    send_sides(16'h0001, 16'hFFFF, 16'hFFFF);
    send_sides(16'hFFFF, 16'h8000, 16'h8000);
    send_sides(16'hFFFF, 16'h7FFF, 16'h8000);
    send_sides(16'hFFFF, 16'hFFFE, 16'h0001);
    send_sides(16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_sides(16'h5555, 16'hAAAA, 16'hAAAA);
    send_sides(16'hAAAA, 16'h5555, 16'h5555);
  endtask

  task automatic test_random_sides();
    repeat (RANDOM_ITEMS) send_random_item();
  endtask

  // Full rate on both sides: no idle input, no output stall.
  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (BURST_ITEMS) send_random_item();
    idle_pct  = BUSY_PCT;
    stall_pct = BUSY_PCT;
  endtask

  // Short bursts, each followed by a full drain of the pipeline.
  task automatic test_drain_pauses();
    repeat (4) begin
      repeat ($urandom_range(1, 30)) send_random_item();
      hold_until_drained();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    in_i           = '0;
    stall_i        = 1'b0;
    idle_pct       = BUSY_PCT;
    stall_pct      = BUSY_PCT;
    mismatch_count = 0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_sides();
    test_back_to_back();
    test_drain_pauses();

    // Drain, then give stray results time to show up.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && area_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/tch_pkg.sv
rtl/tch_factors.sv
rtl/tch_mult.sv
rtl/tch_sqrt_stage.sv
rtl/triangle_check_heron_area.sv
tb/sv/testbench.sv
